### hw/rtl/keypad_matrix_scan_debounce_core_assert.svh
// Assertion macros for the keypad matrix scanner.
`ifndef KEYPAD_MATRIX_SCAN_DEBOUNCE_CORE_ASSERT_SVH
`define KEYPAD_MATRIX_SCAN_DEBOUNCE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define KMSD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define KMSD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/kmsd_pkg.sv
// Shared types, constants and register indexes of the keypad matrix scanner.
`default_nettype none
package kmsd_pkg;

    localparam int unsigned ROWS      = 4;
    localparam int unsigned COLS      = 4;
    localparam int unsigned LINES     = 4;   // physical drive and sense lines
    localparam int unsigned MAP_KEYS  = 16;
    localparam int unsigned CODE_W    = 8;
    localparam int unsigned BCNT_W    = 8;
    localparam int unsigned MAP_W     = 64;
    localparam int unsigned DRV_W     = 2;
    localparam int unsigned POS_W     = 3;
    localparam int unsigned SENSE_W   = 4;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned IDX_RAW_W = $clog2(7 * ROWS + 8);
    localparam int unsigned IDX_W     = (IDX_RAW_W > 4) ? IDX_RAW_W : 4;

    // Line counts, limited to the physical lines.
    localparam logic [POS_W-1:0] DRV_CNT_ROWS = POS_W'((ROWS > LINES) ? LINES : ROWS);
    localparam logic [POS_W-1:0] DRV_CNT_COLS = POS_W'((COLS > LINES) ? LINES : COLS);

    localparam logic [CFG_IDX_W-1:0] CFG_DRIVE_ROWS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NO_KEY_CODE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYMAP_LOW   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KEYMAP_HIGH  = 3'd5;

    typedef enum logic [1:0] {
        PH_SCAN     = 2'd0,
        PH_DEBOUNCE = 2'd1,
        PH_WAIT     = 2'd2
    } t_phase;

    typedef struct packed {
        logic              drive_rows;
        logic [BCNT_W-1:0] debounce_max;
        logic [BCNT_W-1:0] debounce_min;
        logic [CODE_W-1:0] no_key_code;
        logic [MAP_W-1:0]  keymap_low;
        logic [MAP_W-1:0]  keymap_high;
    } t_cfg;

    typedef struct packed {
        logic [DRV_W-1:0]  drive_index;
        logic              scan_done;
        logic              key_found;
        logic [CODE_W-1:0] key_code;
    } t_result;

endpackage
`default_nettype wire

### hw/rtl/kmsd_cfg_regs.sv
// Configuration register file of the keypad matrix scanner.
`default_nettype none
module kmsd_cfg_regs (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [kmsd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [kmsd_pkg::MAP_W-1:0]     i_cfg_data,
    output      kmsd_pkg::t_cfg                 o_cfg
);
    import kmsd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.drive_rows   <= 1'b0;
            r_cfg.debounce_max <= BCNT_W'(20);
            r_cfg.debounce_min <= '0;
            r_cfg.no_key_code  <= CODE_W'(255);
            r_cfg.keymap_low   <= '0;
            r_cfg.keymap_high  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DRIVE_ROWS:   r_cfg.drive_rows   <= i_cfg_data[0];
                CFG_DEBOUNCE_MAX: r_cfg.debounce_max <= i_cfg_data[BCNT_W-1:0];
                CFG_DEBOUNCE_MIN: r_cfg.debounce_min <= i_cfg_data[BCNT_W-1:0];
                CFG_NO_KEY_CODE:  r_cfg.no_key_code  <= i_cfg_data[CODE_W-1:0];
                CFG_KEYMAP_LOW:   r_cfg.keymap_low   <= i_cfg_data;
                CFG_KEYMAP_HIGH:  r_cfg.keymap_high  <= i_cfg_data;
                default: ;  // drop writes to unused indexes
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

### hw/rtl/kmsd_step.sv
// Scan state machine: priority pick, debounce counter and key latch for one sample.
`default_nettype none
module kmsd_step (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_en,
    input  wire logic [kmsd_pkg::SENSE_W-1:0] i_sample,
    input  wire kmsd_pkg::t_cfg               i_cfg,
    output      kmsd_pkg::t_result            o_result
);
    import kmsd_pkg::*;

    t_phase             r_phase,  n_phase;
    logic [DRV_W-1:0]   r_dpos,   n_dpos;
    logic [POS_W-1:0]   r_spos,   n_spos;
    logic [BCNT_W-1:0]  r_bcnt,   n_bcnt;
    logic [CODE_W-1:0]  r_held,   n_held;
    logic               r_seen,   n_seen;
    logic               done;

    logic [POS_W-1:0]   drive_cnt;
    logic [POS_W-1:0]   sense_cnt;
    logic               low_at_pos;
    logic               drv_last;
    logic [BCNT_W-1:0]  bcnt_inc;
    logic [POS_W-1:0]   spos_inc;
    logic               hit;
    logic [POS_W-1:0]   hit_pos;
    logic [POS_W-1:0]   row;
    logic [POS_W-1:0]   col;
    logic [IDX_W-1:0]   key_idx;
    logic [CODE_W-1:0]  keys [MAP_KEYS];
    logic [CODE_W-1:0]  map_code;

    assign drive_cnt  = i_cfg.drive_rows ? DRV_CNT_ROWS : DRV_CNT_COLS;
    assign sense_cnt  = i_cfg.drive_rows ? DRV_CNT_COLS : DRV_CNT_ROWS;
    assign low_at_pos = (r_spos < sense_cnt) && !i_sample[r_spos[1:0]];
    assign drv_last   = ({1'b0, r_dpos} + POS_W'(1)) >= drive_cnt;
    assign bcnt_inc   = (r_bcnt < i_cfg.debounce_max) ? r_bcnt + BCNT_W'(1) : r_bcnt;
    assign spos_inc   = r_spos + POS_W'(1);

    // Lowest pressed sense line at or after the resume position.
    always_comb begin
        hit     = 1'b0;
        hit_pos = '0;
        for (int i = 0; i < SENSE_W; i++) begin
            if (!hit && (POS_W'(i) >= r_spos) && (POS_W'(i) < sense_cnt) && !i_sample[i]) begin
                hit     = 1'b1;
                hit_pos = POS_W'(i);
            end
        end
    end

    // Key map lookup, index col*ROWS+row.
    always_comb begin
        for (int k = 0; k < MAP_KEYS / 2; k++) begin
            keys[k]                = i_cfg.keymap_low[CODE_W*k +: CODE_W];
            keys[k + MAP_KEYS / 2] = i_cfg.keymap_high[CODE_W*k +: CODE_W];
        end
    end

    assign row      = i_cfg.drive_rows ? {1'b0, r_dpos} : r_spos;
    assign col      = i_cfg.drive_rows ? r_spos : {1'b0, r_dpos};
    assign key_idx  = IDX_W'(col) * IDX_W'(ROWS) + IDX_W'(row);
    assign map_code = (key_idx < IDX_W'(MAP_KEYS)) ? keys[key_idx[3:0]] : '0;

    // Next state.
    always_comb begin
        n_phase = r_phase;
        n_dpos  = r_dpos;
        n_spos  = r_spos;
        n_bcnt  = r_bcnt;
        n_held  = r_held;
        n_seen  = r_seen;
        done    = 1'b0;
        case (r_phase)
            PH_DEBOUNCE: begin
                if (low_at_pos) begin
                    n_bcnt = bcnt_inc;
                    if (bcnt_inc == i_cfg.debounce_max) begin
                        n_held  = map_code;
                        n_seen  = 1'b1;
                        n_phase = PH_WAIT;
                    end
                end else if (r_bcnt > i_cfg.debounce_min) begin
                    n_bcnt = r_bcnt - BCNT_W'(1);
                end
            end
            PH_WAIT: begin
                if (!low_at_pos) begin
                    n_phase = PH_SCAN;
                    n_spos  = spos_inc;
                    if (spos_inc >= sense_cnt) begin
                        n_spos = '0;
                        if (drv_last) begin
                            n_dpos = '0;
                            done   = 1'b1;
                        end else begin
                            n_dpos = r_dpos + DRV_W'(1);
                        end
                    end
                end
            end
            default: begin
                if (hit) begin
                    n_phase = PH_DEBOUNCE;
                    n_spos  = hit_pos;
                    n_bcnt  = '0;
                end else begin
                    n_phase = PH_SCAN;
                    n_spos  = '0;
                    if (drv_last) begin
                        n_dpos = '0;
                        done   = 1'b1;
                    end else begin
                        n_dpos = r_dpos + DRV_W'(1);
                    end
                end
            end
        endcase
        if (done) begin
            n_seen = 1'b0;
        end
    end

    // Result of this sample.
    always_comb begin
        o_result.drive_index = n_dpos;
        o_result.scan_done   = done;
        o_result.key_found   = done && r_seen;
        if (!done) begin
            o_result.key_code = '0;
        end else if (r_seen) begin
            o_result.key_code = r_held;
        end else begin
            o_result.key_code = i_cfg.no_key_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_SCAN;
            r_dpos  <= '0;
            r_spos  <= '0;
            r_bcnt  <= '0;
            r_held  <= '0;
            r_seen  <= 1'b0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_dpos  <= n_dpos;
            r_spos  <= n_spos;
            r_bcnt  <= n_bcnt;
            r_held  <= n_held;
            r_seen  <= n_seen;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/keypad_matrix_scan_debounce_core.sv
// Top level of the keypad matrix scanner with debounce.
// An accepted sample item passes the input register, then the output register.
// Throughput: 1 sample item per cycle unless stalled; the state update runs once per item.
// Stalls: a full input register is held while the output register waits on i_out_ready.
// Reset: synchronous, active low; scan phase at drive line 0 and the configuration
// registers at their defaults, both pipeline registers empty.
`default_nettype none
module keypad_matrix_scan_debounce_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // configuration write port
    input  wire logic                           i_cfg_we,
    input  wire logic [kmsd_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [kmsd_pkg::MAP_W-1:0]     i_cfg_data,
    // sample item channel
    input  wire logic                           i_in_valid,
    output      logic                           o_in_ready,
    input  wire logic [kmsd_pkg::SENSE_W-1:0]   i_sense_lines,
    // result item channel
    output      logic                           o_out_valid,
    input  wire logic                           i_out_ready,
    output      logic [kmsd_pkg::DRV_W-1:0]     o_drive_index,
    output      logic                           o_scan_done,
    output      logic                           o_key_found,
    output      logic [kmsd_pkg::CODE_W-1:0]    o_key_code
);
    import kmsd_pkg::*;

    t_cfg                cfg;
    t_result             step_result;

    logic                r_in_valid;
    logic [SENSE_W-1:0]  r_sample;
    logic                r_out_valid;
    t_result             r_out;
    logic                step_en;

    // Process the held sample when the output register is empty or being drained.
    assign step_en    = r_in_valid && (!r_out_valid || i_out_ready);
    // Take a new sample whenever the input register frees up this cycle.
    assign o_in_ready = !r_in_valid || step_en;

    kmsd_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    kmsd_step u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (step_en),
        .i_sample (r_sample),
        .i_cfg    (cfg),
        .o_result (step_result)
    );

    // Input register: hold the sample until the state machine consumes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_sample <= i_sense_lines;
        end
    end

    // Output register: load a fresh result, drop it once taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step_en) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step_en) begin
            r_out <= step_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive_index = r_out.drive_index;
    assign o_scan_done   = r_out.scan_done;
    assign o_key_found   = r_out.key_found;
    assign o_key_code    = r_out.key_code;

`include "keypad_matrix_scan_debounce_core_assert.svh"

    `KMSD_ASSERT_NOW(a_mid_pass_zero, o_out_valid && !o_scan_done, (o_key_found == 1'b0) && (o_key_code == '0), "result fields set on a sample that did not end the pass")
    `KMSD_ASSERT_NOW(a_found_at_done, o_out_valid && o_key_found, o_scan_done, "key reported before the pass ended")
    `KMSD_ASSERT_NOW(a_hold_on_stall, r_in_valid && r_out_valid && !i_out_ready, !o_in_ready, "sample taken while the pipeline is stalled")
    `KMSD_ASSERT_NEXT(a_step_loads_out, step_en, o_out_valid, "processed sample left no result")

endmodule
`default_nettype wire
